@@ sv/dstl_pkg.sv @@
// package for the decimal string to limbs converter
// types, sizes and character codes shared by the interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none
package dstl_pkg;
	localparam int LIMBS_DEF      = 16;
	localparam int DIGITS_MAX_DEF = 144;
	localparam int CHAR_W         = 8;
	localparam int INDEX_W        = 4;
	localparam int VALUE_W        = 30;
	localparam int BCD_W          = 4;
	localparam int GROUP          = 9;

	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [INDEX_W-1:0] limb_index_t;
	typedef logic [VALUE_W-1:0] limb_value_t;
	typedef logic [BCD_W-1:0]   bcd_t;

	localparam char_t CH_NUL   = 8'h00;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;
	localparam char_t CH_MINUS = 8'h2d;

	function automatic logic is_digit(input char_t c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction
endpackage
`default_nettype wire

@@ sv/dstl_if.sv @@
// valid/ready channel interfaces: character items in, limb items out
// depends on dstl_pkg
`timescale 1ns / 1ps
`default_nettype none
interface dstl_char_if;
	import dstl_pkg::*;
	logic  valid;
	logic  ready;
	char_t character;
	modport source (output valid, output character, input ready);
	modport sink (input valid, input character, output ready);
endinterface

interface dstl_limb_if;
	import dstl_pkg::*;
	logic        valid;
	logic        ready;
	limb_index_t limb_index;
	limb_value_t limb_value;
	logic        negative;
	logic        truncated;
	logic        final_limb;
	modport source (output valid, output limb_index, output limb_value, output negative,
		output truncated, output final_limb, input ready);
	modport sink (input valid, input limb_index, input limb_value, input negative,
		input truncated, input final_limb, output ready);
endinterface
`default_nettype wire

@@ sv/dstl_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module dstl_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 144,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

@@ sv/decimal_string_to_limbs.sv @@
// a character item is taken in one cycle; digits are written to the digit ram at once
// on NUL the ram is walked one digit per cycle through its single read port,
// nine digits per limb, limb 0 first; each digit passes the read stage into the
// accumulator, and each finished limb is loaded into the output register
// characters are not taken during the walk; a stalled output holds the walk
// reset clears counters and flags; the digit ram needs no clearing pass
// depends on dstl_pkg, dstl_if, dstl_ram
`timescale 1ns / 1ps
`default_nettype none
module decimal_string_to_limbs #(
	parameter int LIMBS      = dstl_pkg::LIMBS_DEF,
	parameter int DIGITS_MAX = dstl_pkg::DIGITS_MAX_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	dstl_char_if.sink   chars,
	dstl_limb_if.source limbs
);
	import dstl_pkg::*;

	localparam int AW = $clog2(DIGITS_MAX);
	localparam int CW = $clog2(DIGITS_MAX + 1);
	localparam int LW = (LIMBS > 1) ? $clog2(LIMBS) : 1;
	localparam int PW = $clog2(GROUP * LIMBS + GROUP);
	localparam int WW = (PW > CW) ? PW : CW;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_CONV = 2'b10
	} state_t;

	typedef struct packed {
		logic          valid;
		logic          in_range;
		logic          first;
		logic          last;
		logic [LW-1:0] limb;
		logic          neg;
		logic          trunc;
		logic          fin;
	} rd_ctl_t;

	state_t         state_q;
	logic [CW-1:0]  dc_q;
	logic [CW-1:0]  cc_q;
	logic           minus_q;
	logic           stopped_q;
	logic           ovf_q;
	logic [LW-1:0]  limb_q;
	logic [3:0]     dig_q;
	logic [PW-1:0]  pos_q;
	rd_ctl_t        ctl_s1;
	limb_value_t    acc_q;
	logic           out_valid_q;
	limb_index_t    out_index_q;
	limb_value_t    out_value_q;
	logic           out_neg_q;
	logic           out_trunc_q;
	logic           out_fin_q;

	logic           take;
	logic           stall;
	logic           issue;
	logic           last_issue;
	logic           in_range;
	logic [WW-1:0]  diff;
	logic           we;
	bcd_t           rdata;
	bcd_t           digit;
	limb_value_t    acc_base;
	limb_value_t    acc_n;

	// input side
	assign chars.ready = (state_q == ST_IDLE);
	assign take        = chars.valid && chars.ready;
	assign we          = take && (chars.character != CH_NUL)
		&& !(cc_q == '0 && chars.character == CH_MINUS)
		&& !stopped_q && (cc_q < CW'(DIGITS_MAX)) && is_digit(chars.character)
		&& (dc_q < CW'(DIGITS_MAX));

	// walk side
	assign stall      = ctl_s1.valid && ctl_s1.last && out_valid_q && !limbs.ready;
	assign issue      = (state_q == ST_CONV) && !stall;
	assign last_issue = issue && (limb_q == LW'(LIMBS - 1)) && (dig_q == '0);
	assign in_range   = WW'(pos_q) < WW'(dc_q);
	assign diff       = WW'(dc_q) - WW'(pos_q) - WW'(1);

	dstl_ram #(
		.WIDTH(BCD_W),
		.DEPTH(DIGITS_MAX)
	) u_digits (
		.clk  (clk),
		.we   (we),
		.waddr(dc_q[AW-1:0]),
		.wdata(BCD_W'(chars.character - CH_ZERO)),
		.re   (issue),
		.raddr(diff[AW-1:0]),
		.rdata(rdata)
	);

	assign digit    = ctl_s1.in_range ? rdata : '0;
	assign acc_base = ctl_s1.first ? '0 : acc_q;
	assign acc_n    = (acc_base << 3) + (acc_base << 1) + VALUE_W'(digit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dc_q      <= '0;
			cc_q      <= '0;
			minus_q   <= 1'b0;
			stopped_q <= 1'b0;
			ovf_q     <= 1'b0;
			limb_q    <= '0;
			dig_q     <= 4'(GROUP - 1);
			pos_q     <= PW'(GROUP - 1);
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (chars.character == CH_NUL) begin
							state_q <= ST_CONV;
							limb_q  <= '0;
							dig_q   <= 4'(GROUP - 1);
							pos_q   <= PW'(GROUP - 1);
						end else begin
							if (cc_q == '0 && chars.character == CH_MINUS) begin
								minus_q <= 1'b1;
							end else if (!stopped_q) begin
								if (cc_q >= CW'(DIGITS_MAX)) begin
									if (is_digit(chars.character)) begin
										ovf_q <= 1'b1;
									end
								end else if (is_digit(chars.character)) begin
									if (dc_q < CW'(DIGITS_MAX)) begin
										dc_q <= dc_q + CW'(1);
									end
								end else begin
									stopped_q <= 1'b1;
								end
							end
							if (cc_q < CW'(DIGITS_MAX)) begin
								cc_q <= cc_q + CW'(1);
							end
						end
					end
				end
				ST_CONV: begin
					if (issue) begin
						if (dig_q == '0) begin
							dig_q  <= 4'(GROUP - 1);
							pos_q  <= pos_q + PW'(2 * GROUP - 1);
							limb_q <= limb_q + LW'(1);
						end else begin
							dig_q <= dig_q - 4'(1);
							pos_q <= pos_q - PW'(1);
						end
					end
					if (last_issue) begin
						state_q   <= ST_IDLE;
						dc_q      <= '0;
						cc_q      <= '0;
						minus_q   <= 1'b0;
						stopped_q <= 1'b0;
						ovf_q     <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// read stage: one digit per cycle into the accumulator while the output does not stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (!stall) begin
			ctl_s1.valid    <= issue;
			ctl_s1.in_range <= in_range;
			ctl_s1.first    <= (dig_q == 4'(GROUP - 1));
			ctl_s1.last     <= (dig_q == '0);
			ctl_s1.limb     <= limb_q;
			ctl_s1.neg      <= minus_q && (dc_q != '0);
			ctl_s1.trunc    <= ovf_q;
			ctl_s1.fin      <= (limb_q == LW'(LIMBS - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid && !stall) begin
			acc_q <= acc_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl_s1.valid && ctl_s1.last && !stall) begin
			out_valid_q <= 1'b1;
		end else if (limbs.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid && ctl_s1.last && !stall) begin
			out_index_q <= INDEX_W'(ctl_s1.limb);
			out_value_q <= acc_n;
			out_neg_q   <= ctl_s1.neg;
			out_trunc_q <= ctl_s1.trunc;
			out_fin_q   <= ctl_s1.fin;
		end
	end

	assign limbs.valid      = out_valid_q;
	assign limbs.limb_index = out_index_q;
	assign limbs.limb_value = out_value_q;
	assign limbs.negative   = out_neg_q;
	assign limbs.truncated  = out_trunc_q;
	assign limbs.final_limb = out_fin_q;

	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		dc_q <= cc_q)
		else $error("digit count ahead of character count");

	a_final_index: assert property (@(posedge clk) disable iff (!arst_n)
		limbs.valid && limbs.final_limb |-> limbs.limb_index == INDEX_W'(LIMBS - 1))
		else $error("final limb at wrong index");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue && in_range |-> diff < WW'(DIGITS_MAX))
		else $error("digit read out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> $stable(ctl_s1) && $stable(digit))
		else $error("read stage moved during stall");

	a_no_take_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid && !ctl_s1.fin |-> !take)
		else $error("character taken during walk");
endmodule
`default_nettype wire

@@ dv/tb_decimal_string_to_limbs.sv @@
// self-checking testbench for decimal_string_to_limbs: character items in, limb items out
// directed edge-case strings then random strings, checked against typed expectations or an in-bench predictor
// depends on dstl_pkg, dstl_if and the decimal_string_to_limbs rtl
`timescale 1ns / 1ps
module tb_decimal_string_to_limbs;
	import dstl_pkg::*;

	localparam int LIMBS        = LIMBS_DEF;
	localparam int DIGITS_MAX   = DIGITS_MAX_DEF;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_CHARS = 130;
	localparam int MAX_PRINTED  = 40;
	localparam limb_value_t ALL_NINES = 30'd999999999;

	typedef struct packed {
		limb_index_t limb_index;
		limb_value_t limb_value;
		logic        negative;
		logic        truncated;
		logic        final_limb;
	} limb_item_t;

	typedef struct {
		string       head;
		char_t       fill;
		int          reps;
		string       tail;
		bit          typed;
		limb_value_t low_limb;
		limb_value_t upper_limbs;
		bit          negative;
		bit          truncated;
	} string_case_t;

	localparam int N_CASES = 17;
	string_case_t directed_cases [N_CASES] = '{
		'{"",           CH_NUL, 0,   "",   1'b1, 30'd0,     30'd0,     1'b0, 1'b0},
		'{"0",          CH_NUL, 0,   "",   1'b1, 30'd0,     30'd0,     1'b0, 1'b0},
		'{"-",          CH_NUL, 0,   "",   1'b1, 30'd0,     30'd0,     1'b0, 1'b0},
		'{"-0",         CH_NUL, 0,   "",   1'b1, 30'd0,     30'd0,     1'b1, 1'b0},
		'{"999999999",  CH_NUL, 0,   "",   1'b1, ALL_NINES, 30'd0,     1'b0, 1'b0},
		'{"1000000000", CH_NUL, 0,   "",   1'b0, 30'd0,     30'd0,     1'b0, 1'b0},
		'{"-1234567890",CH_NUL, 0,   "",   1'b0, 30'd0,     30'd0,     1'b0, 1'b0},
		'{"12-34",      CH_NUL, 0,   "",   1'b0, 30'd0,     30'd0,     1'b0, 1'b0},
		'{"--5",        CH_NUL, 0,   "",   1'b1, 30'd0,     30'd0,     1'b0, 1'b0},
		'{"7x89/:",     CH_NUL, 0,   "",   1'b0, 30'd0,     30'd0,     1'b0, 1'b0},
		'{"/:",         CH_NUL, 0,   "",   1'b1, 30'd0,     30'd0,     1'b0, 1'b0},
		'{"",           8'hff,  3,   "",   1'b1, 30'd0,     30'd0,     1'b0, 1'b0},
		'{"",           "9",    144, "",   1'b1, ALL_NINES, ALL_NINES, 1'b0, 1'b0},
		'{"",           "9",    145, "",   1'b1, ALL_NINES, ALL_NINES, 1'b0, 1'b1},
		'{"-",          "9",    143, "5",  1'b0, 30'd0,     30'd0,     1'b0, 1'b0},
		'{"",           "8",    144, "a9", 1'b0, 30'd0,     30'd0,     1'b0, 1'b0},
		'{"1x",         "a",    142, "9",  1'b0, 30'd0,     30'd0,     1'b0, 1'b0}
	};

	logic clk;
	logic arst_n;
	int   src_idle_pct;
	int   sink_idle_pct;
	int   cycle;
	int   errors;
	int   limbs_checked;
	int   strings_sent;
	int   chars_sent;
	int   live_chars;

	// predictor state
	bcd_t        digit_buf [DIGITS_MAX];
	int unsigned n_digits;
	int unsigned n_chars;
	bit          minus_flag;
	bit          scan_done;
	bit          overflow_flag;

	limb_item_t limb_forecast [$];
	limb_item_t expected_limbs [$];

	dstl_char_if chars_bus ();
	dstl_limb_if limbs_bus ();

	decimal_string_to_limbs #(
		.LIMBS      (LIMBS),
		.DIGITS_MAX (DIGITS_MAX)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_bus),
		.limbs  (limbs_bus)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d limbs still pending", cycle,
				expected_limbs.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic void clear_scan();
		n_digits      = 0;
		n_chars       = 0;
		minus_flag    = 1'b0;
		scan_done     = 1'b0;
		overflow_flag = 1'b0;
	endfunction

	// one character into the predictor; on NUL the full limb run goes to limb_forecast
	function automatic void forecast_char(input char_t c);
		limb_item_t  item;
		limb_value_t acc;
		int unsigned pos;
		int unsigned d;
		bit          digit;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		if (c == CH_NUL) begin
			for (int k = 0; k < LIMBS; k++) begin
				acc = '0;
				for (int j = GROUP - 1; j >= 0; j--) begin
					pos = k * GROUP + j;
					d = (pos < n_digits) ? int'(digit_buf[n_digits - 1 - pos]) : 0;
					acc = limb_value_t'(acc * 10 + d);
				end
				item.limb_index = limb_index_t'(k);
				item.limb_value = acc;
				item.negative   = minus_flag && (n_digits > 0);
				item.truncated  = overflow_flag;
				item.final_limb = (k == LIMBS - 1);
				limb_forecast.push_back(item);
			end
			clear_scan();
			return;
		end
		if (n_chars == 0 && c == CH_MINUS) begin
			minus_flag = 1'b1;
		end else if (!scan_done) begin
			if (n_chars >= DIGITS_MAX) begin
				if (digit)
					overflow_flag = 1'b1;
			end else if (digit) begin
				if (n_digits < DIGITS_MAX) begin
					digit_buf[n_digits] = bcd_t'(c - CH_ZERO);
					n_digits++;
				end
			end else begin
				scan_done = 1'b1;
			end
		end
		if (n_chars < DIGITS_MAX)
			n_chars++;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("cycle %0d limb %0d: %s got %0d, wanted %0d", cycle, limbs_checked,
				what, got, want);
	endtask

	task automatic check_limb();
		limb_item_t want;
		if (expected_limbs.size() == 0) begin
			report_mismatch("limb item with nothing pending, index", limbs_bus.limb_index, -1);
			return;
		end
		want = expected_limbs.pop_front();
		if (limbs_bus.limb_index !== want.limb_index)
			report_mismatch("limb_index", limbs_bus.limb_index, want.limb_index);
		if (limbs_bus.limb_value !== want.limb_value)
			report_mismatch("limb_value", limbs_bus.limb_value, want.limb_value);
		if (limbs_bus.negative !== want.negative)
			report_mismatch("negative", limbs_bus.negative, want.negative);
		if (limbs_bus.truncated !== want.truncated)
			report_mismatch("truncated", limbs_bus.truncated, want.truncated);
		if (limbs_bus.final_limb !== want.final_limb)
			report_mismatch("final_limb", limbs_bus.final_limb, want.final_limb);
		limbs_checked++;
	endtask

	// valid stays high across back-to-back items
	task automatic send_char(input char_t c);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			chars_bus.valid <= 1'b0;
			@(posedge clk);
		end
		chars_bus.valid     <= 1'b1;
		chars_bus.character <= c;
		@(posedge clk);
		while (!chars_bus.ready)
			@(posedge clk);
		if (c == CH_NUL || !scan_done)
			live_chars++;
		chars_sent++;
		if (c == CH_NUL)
			strings_sent++;
		forecast_char(c);
	endtask

	task automatic send_random_string();
		int kind;
		int n;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			if ($urandom_range(0, 1))
				send_char(CH_MINUS);
			n = ($urandom_range(0, 11) == 0) ? $urandom_range(100, 150) : $urandom_range(0, 27);
			repeat (n)
				send_char(char_t'(CH_ZERO + $urandom_range(0, 9)));
			n = $urandom_range(0, 3);
			repeat (n)
				send_char(char_t'($urandom_range(1, 255)));
		end else if (kind < 9) begin
			n = $urandom_range(0, 20);
			repeat (n) begin
				case ($urandom_range(0, 2))
					0: send_char(char_t'(CH_ZERO + $urandom_range(0, 9)));
					1: send_char(CH_MINUS);
					default: send_char(char_t'($urandom_range(1, 255)));
				endcase
			end
		end else begin
			n = $urandom_range(0, 10);
			repeat (n)
				send_char(char_t'($urandom_range(1, 255)));
		end
		send_char(CH_NUL);
		expected_limbs = {expected_limbs, limb_forecast};
		limb_forecast.delete();
	endtask

	initial begin
		limbs_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (limbs_bus.valid === 1'b1 && limbs_bus.ready === 1'b1)
				check_limb();
			limbs_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	initial begin
		limb_item_t item;
		string_case_t row;
		cycle               = 0;
		errors              = 0;
		limbs_checked       = 0;
		strings_sent        = 0;
		chars_sent          = 0;
		live_chars          = 0;
		src_idle_pct        = 17;
		sink_idle_pct       = 63;
		arst_n              = 1'b0;
		chars_bus.valid     = 1'b0;
		chars_bus.character = CH_NUL;
		clear_scan();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_cases[r]) begin
			row = directed_cases[r];
			for (int i = 0; i < row.head.len(); i++)
				send_char(char_t'(row.head[i]));
			repeat (row.reps)
				send_char(row.fill);
			for (int i = 0; i < row.tail.len(); i++)
				send_char(char_t'(row.tail[i]));
			send_char(CH_NUL);
			if (row.typed) begin
				for (int k = 0; k < LIMBS; k++) begin
					item.limb_index = limb_index_t'(k);
					item.limb_value = (k == 0) ? row.low_limb : row.upper_limbs;
					item.negative   = row.negative;
					item.truncated  = row.truncated;
					item.final_limb = (k == LIMBS - 1);
					expected_limbs.push_back(item);
				end
			end else begin
				expected_limbs = {expected_limbs, limb_forecast};
			end
			limb_forecast.delete();
		end

		live_chars = 0;
		while (live_chars < RANDOM_CHARS) begin
			if (live_chars >= 2 * RANDOM_CHARS / 3) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end else if (live_chars >= RANDOM_CHARS / 3) begin
				src_idle_pct  = 63;
				sink_idle_pct = 17;
			end
			send_random_string();
		end
		chars_bus.valid <= 1'b0;

		while (expected_limbs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d strings (%0d characters), checked %0d limbs, %0d mismatches",
			strings_sent, chars_sent, limbs_checked, errors);
		$display("directed edge strings plus random strings under three idle mixes");
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
